[rtl/rrs_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler package
// Shared widths, codes, controller states and the command and status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int MAX_TASKS_DEF  = 64;
    localparam int TIME_WIDTH_DEF = 32;

    // Fixed field widths of the channels.
    localparam int BURST_W    = 16;
    localparam int ARRIVAL_W  = 16;
    localparam int QUANTUM_W  = 8;
    localparam int TASK_ID_W  = 6;
    localparam int OUT_TIME_W = 32;

    // Quantum after reset.
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd3;

    // Command codes of an input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT_SCAN,
        S_POP,
        S_FETCH,
        S_LOAD_WORK,
        S_UNIT,
        S_SCAN,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // write one task entry into the table
        logic set_started;  // first run command seen
        logic scan_start;   // restart the arrival scan at entry zero
        logic scan_run;     // let the arrival scan walk the table
        logic mark_empty;   // ring was empty, report done
        logic pop;          // take the ring head
        logic latch_id;     // capture the popped task id
        logic load_work;    // capture remaining work and slice start time
        logic unit_step;    // run one time unit
        logic finish;       // write back work, re-queue, close the slice
        logic emit;         // load the result register
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic started;
        logic ring_empty;
        logic scan_done;
        logic unit_more;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/rrs_channels.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler channels
// Valid/ready interfaces for the request, response and quantum write channels.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: task loads and run commands.
interface rrs_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [rrs_pkg::BURST_W-1:0]    burst_units;
    logic [rrs_pkg::ARRIVAL_W-1:0]  arrival_tick;
    logic                           second_queue;

    modport source (output valid, output command, output burst_units,
                    output arrival_tick, output second_queue, input ready);
    modport sink   (input valid, input command, input burst_units,
                    input arrival_tick, input second_queue, output ready);
endinterface

// Response channel: one word per run command.
interface rrs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rrs_pkg::TASK_ID_W-1:0]   task_id;
    logic [rrs_pkg::OUT_TIME_W-1:0]  start_time;
    logic [rrs_pkg::OUT_TIME_W-1:0]  end_time;
    logic                            schedule_done;

    modport source (output valid, output task_id, output start_time,
                    output end_time, output schedule_done, input ready);
    modport sink   (input valid, input task_id, input start_time,
                    input end_time, input schedule_done, output ready);
endinterface

// Configuration channel: quantum writes.
interface rrs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rrs_pkg::QUANTUM_W-1:0]  quantum;

    modport source (output valid, output quantum, input ready);
    modport sink   (input valid, input quantum, output ready);
endinterface

`default_nettype wire

[rtl/round_robin_slice_scheduler.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler
// Holds a task table and a FIFO ready ring; each run command executes one
// time slice of the ring head, enqueuing timed arrivals after every unit.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Word                                              Taken when
//  req      in   command, burst_units, arrival_tick, second_queue  valid & ready
//  rsp      out  task_id, start_time, end_time, schedule_done      valid & ready
//  cfg      in   quantum                                           valid & ready
//
//  A load word is taken while idle. A run word runs up to quantum units
//  of the ring head, and after each unit walks the loaded task table one
//  entry a cycle over its single read port. The first run word adds one
//  table walk before its first pop.
//  Reset clears the counters, time and ring pointers; table memories hold
//  no reset value and need no clearing pass.
//  A result waiting in the output register stalls only the next result.
//
`default_nettype none

module round_robin_slice_scheduler #(
    parameter int MAX_TASKS  = rrs_pkg::MAX_TASKS_DEF,
    parameter int TIME_WIDTH = rrs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rrs_req_if.sink   req,
    rrs_rsp_if.source rsp,
    rrs_cfg_if.sink   cfg
);

    rrs_pkg::ctl_cmd_t   cmd;
    rrs_pkg::dp_status_t status;
    logic                ctl_ready;

    assign req.ready = ctl_ready;

    // Controller.
    rrs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (ctl_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath.
    rrs_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .load_burst   (req.burst_units),
        .load_arrival (req.arrival_tick),
        .load_second  (req.second_queue),
        .cfg          (cfg),
        .rsp          (rsp)
    );

endmodule

`default_nettype wire

[rtl/rrs_ctrl.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler controller
// Sequences loads, the start-up arrival scan, ring pops, time units with
// their arrival scans, and the hand-off of each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_command,
    output logic                     req_ready,
    input  wire rrs_pkg::dp_status_t status,
    output rrs_pkg::ctl_cmd_t        cmd
);

    rrs_pkg::state_t state_reg;
    rrs_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            rrs_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_command == rrs_pkg::CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (!status.started)
                    begin
                        cmd.set_started = 1'b1;
                        cmd.scan_start  = 1'b1;
                        state_next      = rrs_pkg::S_INIT_SCAN;
                    end
                    else
                    begin
                        state_next = rrs_pkg::S_POP;
                    end
                end
            end
            rrs_pkg::S_INIT_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = rrs_pkg::S_POP;
                end
            end
            rrs_pkg::S_POP:
            begin
                if (status.ring_empty)
                begin
                    cmd.mark_empty = 1'b1;
                    state_next     = rrs_pkg::S_EMIT;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = rrs_pkg::S_FETCH;
                end
            end
            rrs_pkg::S_FETCH:
            begin
                cmd.latch_id = 1'b1;
                state_next   = rrs_pkg::S_LOAD_WORK;
            end
            rrs_pkg::S_LOAD_WORK:
            begin
                cmd.load_work = 1'b1;
                state_next    = rrs_pkg::S_UNIT;
            end
            rrs_pkg::S_UNIT:
            begin
                if (status.unit_more)
                begin
                    cmd.unit_step  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = rrs_pkg::S_SCAN;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = rrs_pkg::S_EMIT;
                end
            end
            rrs_pkg::S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = rrs_pkg::S_UNIT;
                end
            end
            rrs_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = rrs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/rrs_datapath.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler datapath
// Task table, ready ring, time counter, arrival scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_datapath #(
    parameter int MAX_TASKS  = rrs_pkg::MAX_TASKS_DEF,
    parameter int TIME_WIDTH = rrs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rrs_pkg::ctl_cmd_t                  cmd,
    output rrs_pkg::dp_status_t                     status,
    input  wire logic [rrs_pkg::BURST_W-1:0]        load_burst,
    input  wire logic [rrs_pkg::ARRIVAL_W-1:0]      load_arrival,
    input  wire logic                               load_second,
    rrs_cfg_if.sink                                 cfg,
    rrs_rsp_if.source                               rsp
);

    localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int ARR_W   = rrs_pkg::ARRIVAL_W + 1;
    localparam int ID_EXT  = (IDX_W > rrs_pkg::TASK_ID_W) ? IDX_W : rrs_pkg::TASK_ID_W;
    localparam int T_EXT   = (TIME_WIDTH > rrs_pkg::OUT_TIME_W) ?
                             TIME_WIDTH : rrs_pkg::OUT_TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

    // Memories: arrival entries, remaining work, ready ring.
    logic [ARR_W-1:0]              arr_mem  [MAX_TASKS];
    logic [rrs_pkg::BURST_W-1:0]   work_mem [MAX_TASKS];
    logic [IDX_W-1:0]              ring_mem [MAX_TASKS];

    logic [ARR_W-1:0]              arr_rd_reg;
    logic [rrs_pkg::BURST_W-1:0]   work_rd_reg;
    logic [IDX_W-1:0]              ring_rd_reg;

    logic [rrs_pkg::QUANTUM_W-1:0] quantum_reg;
    logic [CNT_W-1:0]              task_count_reg;
    logic [IDX_W-1:0]              head_reg;
    logic [IDX_W-1:0]              tail_reg;
    logic [CNT_W-1:0]              ring_count_reg;
    logic                          started_reg;
    logic [TIME_WIDTH-1:0]         time_reg;
    logic [TIME_WIDTH-1:0]         start_reg;
    logic [IDX_W-1:0]              id_reg;
    logic [rrs_pkg::BURST_W-1:0]   rem_reg;
    logic [rrs_pkg::QUANTUM_W-1:0] unit_reg;
    logic                          empty_reg;

    logic [CNT_W-1:0]              scan_idx_reg;
    logic [IDX_W-1:0]              scan_id_reg;
    logic                          scan_pipe_reg;

    logic                          rsp_valid_reg;
    logic [rrs_pkg::TASK_ID_W-1:0] rsp_id_reg;
    logic [rrs_pkg::OUT_TIME_W-1:0] rsp_start_reg;
    logic [rrs_pkg::OUT_TIME_W-1:0] rsp_end_reg;
    logic                          rsp_done_reg;

    logic                          table_write;
    logic                          scan_issue;
    logic                          hit;
    logic                          push_req;
    logic                          push_ok;
    logic [IDX_W-1:0]              push_id;
    logic                          work_we;
    logic [IDX_W-1:0]              work_wa;
    logic [rrs_pkg::BURST_W-1:0]   work_wd;
    logic [ID_EXT-1:0]             id_ext;
    logic [T_EXT-1:0]              time_ext;
    logic [T_EXT-1:0]              start_ext;

    // Quantum register; writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrs_pkg::QUANTUM_RESET;
        end
        else if (cfg.valid)
        begin
            quantum_reg <= cfg.quantum;
        end
    end

    // Table loads are dropped once the table is full.
    assign table_write = cmd.load && (task_count_reg != FULL_CNT);

    // Arrival scan: one table entry read per cycle, compared in the cycle after.
    assign scan_issue = cmd.scan_run && (scan_idx_reg != task_count_reg);
    assign hit        = scan_pipe_reg && arr_rd_reg[ARR_W-1] &&
                        (time_reg == TIME_WIDTH'(arr_rd_reg[rrs_pkg::ARRIVAL_W-1:0]));

    // Ring appends come from scan hits or from the re-queue at slice end.
    assign push_req = hit || (cmd.finish && (rem_reg != '0));
    assign push_id  = hit ? scan_id_reg : id_reg;
    assign push_ok  = push_req && (ring_count_reg != FULL_CNT);

    // Work memory write port: loads and slice write-back.
    always_comb
    begin
        work_we = 1'b0;
        work_wa = task_count_reg[IDX_W-1:0];
        work_wd = load_burst;
        if (table_write)
        begin
            work_we = 1'b1;
        end
        else if (cmd.finish)
        begin
            work_we = 1'b1;
            work_wa = id_reg;
            work_wd = rem_reg;
        end
    end

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (table_write)
        begin
            arr_mem[task_count_reg[IDX_W-1:0]] <= {load_second, load_arrival};
        end
        if (scan_issue)
        begin
            arr_rd_reg <= arr_mem[scan_idx_reg[IDX_W-1:0]];
        end
        if (work_we)
        begin
            work_mem[work_wa] <= work_wd;
        end
        work_rd_reg <= work_mem[ring_rd_reg];
        if (push_ok)
        begin
            ring_mem[tail_reg] <= push_id;
        end
        ring_rd_reg <= ring_mem[head_reg];
    end

    // Control state of the table, ring, scan and time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            ring_count_reg <= '0;
            started_reg    <= 1'b0;
            time_reg       <= '0;
            empty_reg      <= 1'b0;
            scan_idx_reg   <= '0;
            scan_pipe_reg  <= 1'b0;
        end
        else
        begin
            if (table_write)
            begin
                task_count_reg <= task_count_reg + 1'b1;
            end
            if (cmd.set_started)
            begin
                started_reg <= 1'b1;
            end
            if (cmd.unit_step)
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (cmd.mark_empty)
            begin
                empty_reg <= 1'b1;
            end
            else if (cmd.pop)
            begin
                empty_reg <= 1'b0;
            end

            // Pops and appends never fall in the same cycle.
            if (cmd.pop)
            begin
                head_reg       <= (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                ring_count_reg <= ring_count_reg - 1'b1;
            end
            else if (push_ok)
            begin
                tail_reg       <= (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                ring_count_reg <= ring_count_reg + 1'b1;
            end

            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
            end
            else if (scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            scan_pipe_reg <= scan_issue;
        end
    end

    // Scanned entry index and the running slice.
    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            scan_id_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.latch_id)
        begin
            id_reg <= ring_rd_reg;
        end
        if (cmd.load_work)
        begin
            rem_reg   <= work_rd_reg;
            start_reg <= time_reg;
            unit_reg  <= '0;
        end
        else if (cmd.unit_step)
        begin
            rem_reg  <= rem_reg - 1'b1;
            unit_reg <= unit_reg + 1'b1;
        end
    end

    // Result word, formed from the slice registers.
    assign id_ext    = ID_EXT'(id_reg);
    assign time_ext  = T_EXT'(time_reg);
    assign start_ext = T_EXT'(start_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_id_reg    <= empty_reg ? '0 : id_ext[rrs_pkg::TASK_ID_W-1:0];
            rsp_start_reg <= empty_reg ? time_ext[rrs_pkg::OUT_TIME_W-1:0]
                                       : start_ext[rrs_pkg::OUT_TIME_W-1:0];
            rsp_end_reg   <= time_ext[rrs_pkg::OUT_TIME_W-1:0];
            rsp_done_reg  <= empty_reg;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.task_id       = rsp_id_reg;
    assign rsp.start_time    = rsp_start_reg;
    assign rsp.end_time      = rsp_end_reg;
    assign rsp.schedule_done = rsp_done_reg;

    // Status back to the controller.
    always_comb
    begin
        status            = '0;
        status.started    = started_reg;
        status.ring_empty = (ring_count_reg == '0);
        status.scan_done  = (scan_idx_reg == task_count_reg) && !scan_pipe_reg;
        status.unit_more  = (unit_reg < quantum_reg) && (rem_reg != '0);
        status.out_free   = !rsp_valid_reg || rsp.ready;
    end

    // The ring never holds more entries than the table.
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= FULL_CNT)
        else $error("ready ring count exceeds table depth");

    // A pop is only issued on a non-empty ring.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (ring_count_reg != '0))
        else $error("pop from empty ready ring");

    // Scan hits and the slice-end re-queue never compete for the ring.
    a_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(hit && cmd.finish))
        else $error("scan append collides with re-queue");

    // A result loaded into the output register is offered on the next cycle.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp.valid)
        else $error("result word lost after emit");

endmodule

`default_nettype wire
